// ===== src/hvd_pkg.sv =====
`default_nettype none

package hvd_pkg;

  // datapath widths
  localparam int unsigned CW = 34;  // CORDIC x/y and Q30 products
  localparam int unsigned ZW = 33;  // CORDIC angle accumulator
  localparam int unsigned MW = 31;  // angle magnitude in 1e-7 degree, and Q30 radians
  localparam int unsigned SQW = 61; // isqrt radicand: Q30 value shifted up by 30
  localparam int unsigned ISQRT_STEPS = 31;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(34'sh26DD3B6A);
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // 1e-7 degree to Q62 radians, split for two narrow multipliers
  localparam logic [32:0] DEG_K = 33'd8048910508;
  localparam int unsigned K_LO_W = 17;
  localparam logic [15:0] DEG_K_HI = DEG_K[32:17];
  localparam logic [16:0] DEG_K_LO = DEG_K[16:0];

  localparam logic signed [34:0] FULL_TURN = 35'sd3600000000;
  localparam logic signed [34:0] HALF_TURN = 35'sd1800000000;
  localparam logic [30:0] QUARTER_TURN = 31'd900000000;
  localparam logic [30:0] HALF_TURN_U = 31'd1800000000;

  // arctangent of 2^-i in Q30
  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0: r = 32'd843314857;
      1: r = 32'd497837829;
      2: r = 32'd263043837;
      3: r = 32'd133525159;
      4: r = 32'd67021687;
      5: r = 32'd33543516;
      6: r = 32'd16775851;
      7: r = 32'd8388437;
      8: r = 32'd4194283;
      9: r = 32'd2097149;
      10: r = 32'd1048576;
      11: r = 32'd524288;
      default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/hvd_cordic_rot.sv =====
`default_nettype none

// Pipelined CORDIC rotation: one micro-rotation per stage, sin/cos in Q30.
module hvd_cordic_rot
  import hvd_pkg::*;
#(
  parameter int unsigned STAGES = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [MW-1:0]        angle_i,
  output logic                      valid_o,
  output logic signed [CW-1:0]      sin_o,
  output logic signed [CW-1:0]      cos_o
);

  logic signed [CW-1:0] x_q [STAGES];
  logic signed [CW-1:0] y_q [STAGES];
  logic signed [ZW-1:0] z_q [STAGES];
  logic signed [CW-1:0] x_d [STAGES];
  logic signed [CW-1:0] y_d [STAGES];
  logic signed [ZW-1:0] z_d [STAGES];
  logic [STAGES-1:0]    v_q;

  always_comb begin
    logic signed [CW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] zs, at;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        xs = CORDIC_GAIN;
        ys = '0;
        zs = $signed(ZW'(angle_i));
      end else begin
        xs = x_q[i-1];
        ys = y_q[i-1];
        zs = z_q[i-1];
      end
      dx = ys >>> i;
      dy = xs >>> i;
      at = $signed(ZW'(atan_entry(i)));
      if (zs >= 0) begin
        x_d[i] = xs - dx;
        y_d[i] = ys + dy;
        z_d[i] = zs - at;
      end else begin
        x_d[i] = xs + dx;
        y_d[i] = ys - dy;
        z_d[i] = zs + at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < STAGES; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign sin_o   = y_q[STAGES-1];
  assign cos_o   = x_q[STAGES-1];

endmodule

`default_nettype wire

// ===== src/hvd_isqrt.sv =====
`default_nettype none

// Pipelined restoring integer square root, one result bit per stage.
module hvd_isqrt
  import hvd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [SQW-1:0] rad_i,
  output logic                valid_o,
  output logic [MW-1:0]       root_o
);

  logic [SQW-1:0] v_q [ISQRT_STEPS];
  logic [SQW-1:0] r_q [ISQRT_STEPS];
  logic [SQW-1:0] v_d [ISQRT_STEPS];
  logic [SQW-1:0] r_d [ISQRT_STEPS];
  logic [ISQRT_STEPS-1:0] vl_q;

  always_comb begin
    logic [SQW-1:0] vs, rs, bt;
    logic [SQW:0]   trial;
    for (int i = 0; i < ISQRT_STEPS; i++) begin
      if (i == 0) begin
        vs = rad_i;
        rs = '0;
      end else begin
        vs = v_q[i-1];
        rs = r_q[i-1];
      end
      bt = SQW'(1) << (2 * (ISQRT_STEPS - 1 - i));
      trial = {1'b0, rs} + {1'b0, bt};
      if ({1'b0, vs} >= trial) begin
        v_d[i] = vs - SQW'(trial);
        r_d[i] = (rs >> 1) + bt;
      end else begin
        v_d[i] = vs;
        r_d[i] = rs >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[ISQRT_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < ISQRT_STEPS; i++) begin
        v_q[i] <= v_d[i];
        r_q[i] <= r_d[i];
      end
    end
  end

  assign valid_o = vl_q[ISQRT_STEPS-1];
  assign root_o  = r_q[ISQRT_STEPS-1][MW-1:0];

endmodule

`default_nettype wire

// ===== src/hvd_cordic_vec.sv =====
`default_nettype none

// Pipelined CORDIC vectoring: atan2(y, x) for x, y >= 0, returned doubled.
module hvd_cordic_vec
  import hvd_pkg::*;
#(
  parameter int unsigned STAGES = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [MW-1:0] y_i,
  input  wire logic [MW-1:0] x_i,
  output logic               valid_o,
  output logic [MW:0]        ang2_o
);

  logic signed [CW-1:0] x_q [STAGES];
  logic signed [CW-1:0] y_q [STAGES];
  logic signed [ZW-1:0] z_q [STAGES];
  logic signed [CW-1:0] x_d [STAGES];
  logic signed [CW-1:0] y_d [STAGES];
  logic signed [ZW-1:0] z_d [STAGES];
  logic [STAGES-1:0]    v_q;
  logic signed [ZW-1:0] z_last;

  always_comb begin
    logic signed [CW-1:0] xs, ys, dx, dy;
    logic signed [ZW-1:0] zs, at;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        xs = $signed(CW'(x_i));
        ys = $signed(CW'(y_i));
        zs = '0;
      end else begin
        xs = x_q[i-1];
        ys = y_q[i-1];
        zs = z_q[i-1];
      end
      dx = ys >>> i;
      dy = xs >>> i;
      at = $signed(ZW'(atan_entry(i)));
      if (ys >= 0) begin
        x_d[i] = xs + dx;
        y_d[i] = ys - dy;
        z_d[i] = zs + at;
      end else begin
        x_d[i] = xs - dx;
        y_d[i] = ys + dy;
        z_d[i] = zs - at;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < STAGES; i++) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
      end
    end
  end

  // negative residue clamps to zero; z stays below pi/2 so 2z fits
  assign z_last  = z_q[STAGES-1];
  assign valid_o = v_q[STAGES-1];
  assign ang2_o  = (z_last < 0) ? '0 : {z_last[MW-1:0], 1'b0};

endmodule

`default_nettype wire

// ===== src/haversine_distance.sv =====
`default_nettype none

// Channel  Handshake                 Payload
// in       in_valid_i / in_stall_o   lat_a_i, lon_a_i, lat_b_i, lon_b_i
// out      out_valid_o / out_stall_i distance_cm_o
// cfg      cfg_valid_i / cfg_ready_o cfg_sphere_radius_m_i
//
// One request per cycle in, one result per cycle out, unless stalled.
// Pipeline stages: front end 4, sin/cos CORDIC, products 4, square root 31,
// atan2 CORDIC, scaling 2.
// The whole pipeline freezes while a result waits on out_stall_i; empty
// stages do not hold back the next request beyond that.
// Reset clears all valid bits and loads the radius with 6371000 m.
module haversine_distance
  import hvd_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [30:0] lat_a_i,
  input  wire logic signed [31:0] lon_a_i,
  input  wire logic signed [30:0] lat_b_i,
  input  wire logic signed [31:0] lon_b_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [31:0]             distance_cm_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [22:0]        cfg_sphere_radius_m_i
);

  // Q30 multiply, rounded half up
  function automatic logic signed [CW-1:0] qmul(input logic signed [CW-1:0] p,
                                                input logic signed [CW-1:0] q);
    logic signed [2*CW-1:0] pr;
    pr = (2*CW)'(p) * (2*CW)'(q);
    pr = pr + (2*CW)'(64'sd536870912);
    return CW'(pr >>> 30);
  endfunction

  // reduce a difference into [-180, 180) degrees and take its magnitude
  function automatic logic [MW-1:0] wrap_mag(input logic signed [34:0] d);
    logic signed [34:0] r;
    r = d;
    if (d >= HALF_TURN) begin
      r = d - FULL_TURN;
    end else if (d < -HALF_TURN) begin
      r = d + FULL_TURN;
    end
    if (r < 0) begin
      r = -r;
    end
    return r[MW-1:0];
  endfunction

  logic en;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // radius register and its scale to centimetres
  logic [22:0] radius_q;
  logic [29:0] r100_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 23'd6371000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radius_q <= cfg_sphere_radius_m_i;
    end
  end
  always_ff @(posedge clk_i) begin
    r100_q <= 30'(radius_q) * 30'd100;
  end

  // ---- front end: differences, range reduction, degree to radian ----
  logic              f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic signed [31:0] dlat_q;
  logic signed [32:0] dlon_q;
  logic [MW-1:0]      ua_q, ub_q;
  logic [MW-1:0]      mag_q [4];  // dlat, dlon, lat_a, lat_b
  logic [1:0]         flip2_q, flip3_q, flip4_q;
  logic [46:0]        ph_q [4];
  logic [47:0]        pl_q [4];
  logic [MW-1:0]      ang_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0] p;
    if (en) begin
      dlat_q <= 32'(lat_b_i) - 32'(lat_a_i);
      dlon_q <= 33'(lon_b_i) - 33'(lon_a_i);
      ua_q   <= lat_a_i[30] ? MW'(-lat_a_i) : MW'(lat_a_i);
      ub_q   <= lat_b_i[30] ? MW'(-lat_b_i) : MW'(lat_b_i);

      mag_q[0] <= wrap_mag(35'(dlat_q));
      mag_q[1] <= wrap_mag(35'(dlon_q));
      // beyond a quarter turn use cos(x) = -cos(180 - x)
      mag_q[2] <= (ua_q > QUARTER_TURN) ? HALF_TURN_U - ua_q : ua_q;
      mag_q[3] <= (ub_q > QUARTER_TURN) ? HALF_TURN_U - ub_q : ub_q;
      flip2_q  <= {ub_q > QUARTER_TURN, ua_q > QUARTER_TURN};

      for (int k = 0; k < 4; k++) begin
        ph_q[k] <= 47'(mag_q[k]) * 47'(DEG_K_HI);
        pl_q[k] <= 48'(mag_q[k]) * 48'(DEG_K_LO);
      end
      flip3_q <= flip2_q;

      for (int k = 0; k < 4; k++) begin
        p = (64'(ph_q[k]) << K_LO_W) + 64'(pl_q[k]);
        if (k < 2) begin
          ang_q[k] <= MW'((p + 64'h1_0000_0000) >> 33);  // half angle
        end else begin
          ang_q[k] <= MW'((p + 64'h8000_0000) >> 32);
        end
      end
      flip4_q <= flip3_q;
    end
  end

  // ---- sin/cos CORDICs ----
  logic                 c_v [4];
  logic signed [CW-1:0] c_sin [4];
  logic signed [CW-1:0] c_cos [4];

  for (genvar k = 0; k < 4; k++) begin : g_rot
    hvd_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (f4_v_q),
      .angle_i (ang_q[k]),
      .valid_o (c_v[k]),
      .sin_o   (c_sin[k]),
      .cos_o   (c_cos[k])
    );
  end

  // latitude flips ride alongside the CORDIC stages
  logic [1:0] flip_dly_q [CORDIC_STAGES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      flip_dly_q[0] <= flip4_q;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
        flip_dly_q[i] <= flip_dly_q[i-1];
      end
    end
  end

  // ---- products and a ----
  logic                 m0_v_q, m1_v_q, m2_v_q, m3_v_q;
  logic signed [CW-1:0] s_lat_q, s_lon_q, cos_a_q, cos_b_q;
  logic signed [CW-1:0] ss_lat_q, ss_lon_q, cc_q, ss_lat2_q, t_q;
  logic [MW-1:0]        a_q, b_q;
  logic signed [CW:0]   a_sum;

  assign a_sum = (CW+1)'(ss_lat2_q) + (CW+1)'(t_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_v_q <= 1'b0;
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (en) begin
      m0_v_q <= c_v[0];
      m1_v_q <= m0_v_q;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_lat_q <= c_sin[0];
      s_lon_q <= c_sin[1];
      cos_a_q <= flip_dly_q[CORDIC_STAGES-1][0] ? -c_cos[2] : c_cos[2];
      cos_b_q <= flip_dly_q[CORDIC_STAGES-1][1] ? -c_cos[3] : c_cos[3];

      ss_lat_q <= qmul(s_lat_q, s_lat_q);
      ss_lon_q <= qmul(s_lon_q, s_lon_q);
      cc_q     <= qmul(cos_a_q, cos_b_q);

      ss_lat2_q <= ss_lat_q;
      t_q       <= qmul(cc_q, ss_lon_q);

      // clamp a to [0, 1]
      if (a_sum < 0) begin
        a_q <= '0;
        b_q <= Q30_ONE;
      end else if (a_sum > $signed((CW+1)'(Q30_ONE))) begin
        a_q <= Q30_ONE;
        b_q <= '0;
      end else begin
        a_q <= a_sum[MW-1:0];
        b_q <= Q30_ONE - a_sum[MW-1:0];
      end
    end
  end

  // ---- square roots ----
  logic          sa_v, sb_v;
  logic [MW-1:0] sa, sb;

  hvd_isqrt u_sqrt_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m3_v_q),
    .rad_i   ({a_q, 30'd0}),
    .valid_o (sa_v),
    .root_o  (sa)
  );

  hvd_isqrt u_sqrt_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m3_v_q),
    .rad_i   ({b_q, 30'd0}),
    .valid_o (sb_v),
    .root_o  (sb)
  );

  // ---- central angle ----
  logic        ang_v;
  logic [MW:0] ang2;

  hvd_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sa_v),
    .y_i     (sa),
    .x_i     (sb),
    .valid_o (ang_v),
    .ang2_o  (ang2)
  );

  // ---- scale by radius, round to centimetres ----
  logic        p1_v_q, out_v_q;
  logic [61:0] prod_q;
  logic [61:0] prod_rnd;
  logic [31:0] dist_q;

  assign prod_rnd = prod_q + 62'h2000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q  <= ang_v;
      out_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 62'(r100_q) * 62'(ang2);
      dist_q <= prod_rnd[61:30];
    end
  end

  assign out_valid_o   = out_v_q;
  assign distance_cm_o = dist_q;

  // ---- checks ----
  property p_cfg_write;
    @(posedge clk_i) disable iff (!rst_ni)
      cfg_valid_i && cfg_ready_o |=> radius_q == $past(cfg_sphere_radius_m_i);
  endproperty
  a_cfg_write: assert property (p_cfg_write) else $error("radius write lost");

  property p_a_range;
    @(posedge clk_i) disable iff (!rst_ni)
      m3_v_q |-> (a_q <= Q30_ONE) && (32'(a_q) + 32'(b_q) == 32'(Q30_ONE));
  endproperty
  a_a_range: assert property (p_a_range) else $error("a out of range");

  property p_enter;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && !in_stall_o |=> f1_v_q;
  endproperty
  a_enter: assert property (p_enter) else $error("accepted request dropped");

  // the four sin/cos lanes move in lockstep
  property p_rot_align;
    @(posedge clk_i) disable iff (!rst_ni)
      (c_v[0] == c_v[1]) && (c_v[0] == c_v[2]) && (c_v[0] == c_v[3]);
  endproperty
  a_rot_align: assert property (p_rot_align) else $error("sin/cos lanes out of step");

  property p_sqrt_align;
    @(posedge clk_i) disable iff (!rst_ni)
      sa_v == sb_v;
  endproperty
  a_sqrt_align: assert property (p_sqrt_align) else $error("square roots out of step");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

// Haversine distance block: point pairs go in, one distance per request
// comes out. Each accepted request is run through a bit-exact fixed-point
// predictor below, or given a typed value, and the expected distance is
// queued; results are matched in order. The run walks several radius
// settings and several mixes of sender idling and receiver stalling.
module tb;
  import hvd_pkg::*;

  localparam int unsigned STAGES = 32;
  // pipeline depth given for the block; drain adds a margin
  localparam int unsigned PIPE_LAT = 2 * STAGES + 41;
  localparam longint Q_ONE = 64'sd1 << 30;
  localparam longint Q_HALF = 64'sd1 << 29;
  localparam longint GAIN_INV = 64'sh26DD3B6A;
  localparam longint unsigned RAD_K = 64'hC90FDAA22168C234 / 64'd1800000000;
  localparam longint TURN = 64'sd3600000000;
  localparam longint HALF_T = 64'sd1800000000;
  localparam longint QUART_T = 64'sd900000000;
  localparam logic [22:0] EARTH_M = 23'd6371000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
  } pair_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [30:0] lat_a = '0;
  logic signed [31:0] lon_a = '0;
  logic signed [30:0] lat_b = '0;
  logic signed [31:0] lon_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        dist_cm;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [22:0]        cfg_radius = '0;

  // predictor copy of the radius register
  logic [22:0] radius_m = EARTH_M;
  // distances still owed by the block, oldest first
  logic [31:0] dist_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;

  haversine_distance #(.CORDIC_STAGES(STAGES)) dut (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .lat_a_i              (lat_a),
    .lon_a_i              (lon_a),
    .lat_b_i              (lat_b),
    .lon_b_i              (lon_b),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .distance_cm_o        (dist_cm),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_sphere_radius_m_i(cfg_radius)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- predictor ----------------

  function automatic longint atan_q30(input int i);
    longint tab[12];
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288};
    if (i < 12) return tab[i];
    if (i <= 30) return 64'sd1 << (30 - i);
    return 0;
  endfunction

  // Q30 product, rounded half up (>>> floors like the hardware)
  function automatic longint q_mul(input longint p, input longint q);
    return (p * q + Q_HALF) >>> 30;
  endfunction

  // rotation mode: sine and cosine of a Q30 angle
  function automatic void rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = GAIN_INV; y = 0; z = ang;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    s = y;
    c = x;
  endfunction

  // vectoring mode: atan2(y, x) in Q30, floored at zero
  function automatic longint vector_angle(input longint y0, input longint x0);
    longint x, y, z, dx, dy;
    x = x0; y = y0; z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q30(i);
      end else begin
        x -= dx; y += dy; z -= atan_q30(i);
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sin^2 of half an angle difference; the difference wraps mod 360 deg
  function automatic longint half_sin_sq(input longint d);
    longint r, s, c;
    longint unsigned mag;
    r = d % TURN;
    if (r < 0) r += TURN;
    if (r >= HALF_T) r -= TURN;
    mag = (r < 0) ? -r : r;
    rotate(longint'((mag * RAD_K + (64'd1 << 32)) >> 33), s, c);
    return q_mul(s, s);
  endfunction

  // latitudes past the pole fold back with a sign flip on the cosine
  function automatic longint lat_cosine(input longint lat);
    longint u, s, c;
    bit flip;
    u = (lat < 0) ? -lat : lat;
    flip = u > QUART_T;
    if (flip) u = HALF_T - u;
    rotate(longint'((longint'(u) * RAD_K + (64'd1 << 31)) >> 32), s, c);
    return flip ? -c : c;
  endfunction

  function automatic logic [31:0] great_circle_cm(input pair_t p, input logic [22:0] rad);
    longint a, ang;
    longint unsigned sa, sb, prod;
    a = half_sin_sq(longint'(p.lat_b) - longint'(p.lat_a)) +
        q_mul(q_mul(lat_cosine(p.lat_a), lat_cosine(p.lat_b)),
              half_sin_sq(longint'(p.lon_b) - longint'(p.lon_a)));
    if (a < 0) a = 0;
    if (a > Q_ONE) a = Q_ONE;
    sa = int_sqrt(longint'(a) << 30);
    sb = int_sqrt(longint'(Q_ONE - a) << 30);
    ang = 2 * vector_angle(sa, sb);
    prod = longint'(rad) * 100 * ang + (64'd1 << 29);
    return prod[61:30];
  endfunction

  // ---------------- directed requests ----------------

  localparam int N_DIR = 16;
  pair_t dir_tab[N_DIR] = '{
    '{31'sd0, 32'sd0, 31'sd0, 32'sd0},                    // same point
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1},                    // smallest step
    '{31'sd1, 32'sd0, 31'sd0, 32'sd0},
    '{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0},   // pole to pole
    '{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000},           // antipodal, equator
    '{31'sd450000000, 32'sd0, -31'sd450000000, 32'sd1800000000},
    '{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000}, // wraps to same point
    '{31'sd0, 32'sd1799999999, 31'sd0, -32'sd1799999999},
    '{-31'sd900000000, 32'sd123, -31'sd900000000, -32'sd456}, // both at pole
    '{31'sd899999999, 32'sd0, 31'sd899999999, 32'sd1800000000},
    '{31'sd455000000, -32'sd1220000000, 31'sd407000000, -32'sd740000000},
    '{31'sd1000000000, 32'sd0, 31'sd1000000000, 32'sd0},  // past the pole
    '{31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000}, // field extremes
    '{31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF},
    '{31'sd0, 32'sd0, 31'sd0, 32'h7FFF_FFFF},
    '{31'sd0, 32'sd0, 31'sd0, 32'h8000_0000}
  };

  // ---------------- stimulus helpers ----------------

  function automatic pair_t rand_pair();
    pair_t p;
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      p.lat_a = 31'(longint'($urandom_range(1800000000)) - 900000000);
      p.lon_a = 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
      p.lat_b = 31'(longint'($urandom_range(1800000000)) - 900000000);
      p.lon_b = 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
    end else if (kind < 85) begin
      // raw bits, often out of range
      p.lat_a = 31'($urandom);
      p.lon_a = $urandom;
      p.lat_b = 31'($urandom);
      p.lon_b = $urandom;
    end else begin
      // near-antipodal and near-coincident pairs
      p.lat_a = 31'(longint'($urandom_range(1800000000)) - 900000000);
      p.lon_a = 32'(longint'($urandom_range(32'd3600000000)) - 1800000000);
      if ($urandom_range(1)) begin
        p.lat_b = -p.lat_a + 31'(longint'($urandom_range(2000)) - 1000);
        p.lon_b = p.lon_a + 32'sd1800000000 + 32'(longint'($urandom_range(2000)) - 1000);
      end else begin
        p.lat_b = p.lat_a + 31'(longint'($urandom_range(200)) - 100);
        p.lon_b = p.lon_a + 32'(longint'($urandom_range(200)) - 100);
      end
    end
    return p;
  endfunction

  // offer one request; on acceptance queue its distance
  task automatic send_pair(input pair_t p, input bit typed, input logic [31:0] typed_cm);
    in_valid <= 1'b1;
    lat_a <= p.lat_a;
    lon_a <= p.lon_a;
    lat_b <= p.lat_b;
    lon_b <= p.lon_b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    dist_q = {dist_q, typed ? typed_cm : great_circle_cm(p, radius_m)};
    // each cycle after an accept is idle with probability idle_pct
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // radius writes happen only with the pipeline empty
  task automatic write_radius(input logic [22:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_radius <= r;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    radius_m = r;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_pair(), 1'b0, '0);
  endtask

  // ---------------- receiver ----------------

  // random stall, plus a long hold-off whenever hold_req toggles
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (dist_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: distance %0d with nothing expected", dist_cm);
      end else if (dist_cm !== dist_q[0]) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: distance_cm expected %0d got %0d", dist_q[0], dist_cm);
        void'(dist_q.pop_front());
      end else begin
        void'(dist_q.pop_front());
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass at the reset radius, no idling
    for (int i = 0; i < N_DIR; i++) send_pair(dir_tab[i], 1'b0, '0);

    // back-to-back requests while the receiver holds off: pipeline fills
    hold_req <= 1'b1;
    send_random(240);

    // sender idles, largest radius
    write_radius(23'h7F_FFFF);
    idle_pct = 70;
    send_random(240);

    // receiver stalls, smallest radius
    write_radius(23'd1);
    idle_pct = 0;
    stall_pct = 70;
    send_random(240);

    // zero radius: every distance is zero
    write_radius(23'd0);
    idle_pct = 24;
    stall_pct = 24;
    for (int i = 0; i < N_DIR; i++) send_pair(dir_tab[i], 1'b1, 32'd0);
    send_random(40);

    // random radius, then a pause until everything is back
    write_radius(23'($urandom_range(1, 23'h7F_FFFF)));
    send_random(120);
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    send_random(100);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
